// ----- hw/rtl/square_matrix_vector_multiply_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the square matrix-vector multiply block
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SMVM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/smvm_pkg.sv -----
// ----------------------------------------------------------------------------
// Square matrix-vector multiply package
// Widths, command codes and the operation record passed from front to back.
// ----------------------------------------------------------------------------
package smvm_pkg;

    // Largest supported matrix order and derived widths.
    localparam int MAX_ORDER   = 1024;
    localparam int ADDR_W      = $clog2(MAX_ORDER);
    localparam int ORDER_W     = 11;
    localparam int VALUE_W     = 32;
    localparam int SUM_W       = 64;

    // Depth of the operation queue and of the result queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Saturation limits of the row accumulator.
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Input command codes.
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } t_cmd;

    // One matrix element with its vector operand and row bookkeeping.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] vec;
        logic                      first;
        logic                      last;
        logic [ADDR_W-1:0]         row;
        logic                      final_row;
    } t_op;

endpackage

// ----- hw/rtl/smvm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module smvm_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/smvm_front.sv -----
// ----------------------------------------------------------------------------
// Square matrix-vector multiply front end
// Accepts transactions, keeps the load, column and row positions, holds the
// vector store and issues one operation per matrix element.
// ----------------------------------------------------------------------------
module smvm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [smvm_pkg::ORDER_W-1:0]       i_cfg_wr_data,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_command,
    input  logic signed [smvm_pkg::VALUE_W-1:0] i_value,
    output logic                               o_op_valid,
    output smvm_pkg::t_op                      o_op,
    input  logic                               i_op_full
);

    import smvm_pkg::*;

    logic [ORDER_W-1:0] r_order;
    logic [ADDR_W-1:0]  r_load_pos, n_load_pos;
    logic [ADDR_W-1:0]  r_col_pos,  n_col_pos;
    logic [ADDR_W-1:0]  r_row_pos,  n_row_pos;
    logic               r_s1_valid, n_s1_valid;
    t_op                r_s1,       n_s1;

    logic [ORDER_W-1:0] order_eff;
    logic [ADDR_W-1:0]  load_w, col_w, row_w;
    logic [ORDER_W-1:0] load_inc, col_inc, row_inc;
    logic               s1_go, accept, is_load, is_matrix;
    logic [VALUE_W-1:0] ram_rdata;

    // Order register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(1);
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    // Effective order: zero acts as one, anything too large is clamped.
    always_comb begin
        if (r_order == '0) begin
            order_eff = ORDER_W'(1);
        end else if (r_order > ORDER_W'(MAX_ORDER)) begin
            order_eff = ORDER_W'(MAX_ORDER);
        end else begin
            order_eff = r_order;
        end
    end

    // Stage one moves on when it is empty or the queue can take its operation.
    assign s1_go     = !r_s1_valid || !i_op_full;
    assign full      = !s1_go;
    assign accept    = push && s1_go;
    assign is_load   = accept && (i_command == CMD_LOAD);
    assign is_matrix = accept && (i_command == CMD_MATRIX);

    // Positions that have fallen beyond the order restart at zero.
    assign load_w   = ({1'b0, r_load_pos} >= order_eff) ? '0 : r_load_pos;
    assign col_w    = ({1'b0, r_col_pos}  >= order_eff) ? '0 : r_col_pos;
    assign row_w    = ({1'b0, r_row_pos}  >= order_eff) ? '0 : r_row_pos;
    assign load_inc = {1'b0, load_w} + ORDER_W'(1);
    assign col_inc  = {1'b0, col_w}  + ORDER_W'(1);
    assign row_inc  = {1'b0, row_w}  + ORDER_W'(1);

    // Position bookkeeping and the stage one operation record.
    // A row sum starts afresh only when the stored column position is zero; a
    // column left beyond a shrunken order restarts without clearing the sum.
    always_comb begin
        n_load_pos = r_load_pos;
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (s1_go) begin
            n_s1_valid = is_matrix;
        end
        if (is_load) begin
            n_load_pos = (load_inc >= order_eff) ? '0 : load_inc[ADDR_W-1:0];
            n_col_pos  = '0;
            n_row_pos  = '0;
        end else if (is_matrix) begin
            n_s1.value     = i_value;
            n_s1.vec       = '0;
            n_s1.first     = (r_col_pos == '0);
            n_s1.last      = (col_inc >= order_eff);
            n_s1.row       = row_w;
            n_s1.final_row = (row_inc >= order_eff);
            if (col_inc >= order_eff) begin
                n_col_pos = '0;
                n_row_pos = (row_inc >= order_eff) ? '0 : row_inc[ADDR_W-1:0];
            end else begin
                n_col_pos = col_inc[ADDR_W-1:0];
                n_row_pos = row_w;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_load_pos <= n_load_pos;
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
            r_s1_valid <= n_s1_valid;
        end
    end

    // Payload register of stage one.
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // Vector store: written by loads, read for the column of each matrix element.
    smvm_ram #(
        .DATA_W (VALUE_W),
        .DEPTH  (MAX_ORDER)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (is_load),
        .i_waddr (load_w),
        .i_wdata (i_value),
        .i_re    (is_matrix),
        .i_raddr (col_w),
        .o_rdata (ram_rdata)
    );

    // Operation handed to the queue, completed with the vector element.
    always_comb begin
        o_op     = r_s1;
        o_op.vec = ram_rdata;
    end

    assign o_op_valid = r_s1_valid && !i_op_full;

endmodule

// ----- hw/rtl/smvm_queue.sv -----
// ----------------------------------------------------------------------------
// Square matrix-vector multiply operation queue
// Short first-in first-out queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module smvm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smvm_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output smvm_pkg::t_op o_op,
    output logic          o_empty
);

    import smvm_pkg::*;

    t_op                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= QUEUE_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= QUEUE_PTR_W'(r_rd_ptr + 1'b1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ----- hw/rtl/smvm_back.sv -----
// ----------------------------------------------------------------------------
// Square matrix-vector multiply back end
// Multiplies each matrix element by its vector element, accumulates the row
// with saturation and queues finished row sums for the result side.
// ----------------------------------------------------------------------------
`include "square_matrix_vector_multiply_defines.svh"

module smvm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smvm_pkg::t_op                      i_op,
    input  logic                               i_op_empty,
    output logic                               o_op_pop,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [smvm_pkg::SUM_W-1:0]  o_row_sum,
    output logic [smvm_pkg::ADDR_W-1:0]        o_row_index,
    output logic                               o_final_row
);

    import smvm_pkg::*;

    // Multiply stage.
    logic                    r_b1_valid;
    logic signed [SUM_W-1:0] r_b1_prod;
    logic                    r_b1_first, r_b1_last, r_b1_final;
    logic [ADDR_W-1:0]       r_b1_row;

    // Accumulator.
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic signed [SUM_W-1:0] acc_base, acc_sum;
    logic                    acc_ovf;

    // Result queue.
    logic signed [SUM_W-1:0] r_out_sum   [QUEUE_DEPTH];
    logic [ADDR_W-1:0]       r_out_row   [QUEUE_DEPTH];
    logic                    r_out_final [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_out_wr_ptr, r_out_rd_ptr;
    logic [QUEUE_PTR_W:0]    r_out_count;

    logic advance, out_push, out_pop;

    // The whole back end holds while the result queue is full.
    assign advance  = (r_out_count != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_op_pop = advance && !i_op_empty;
    assign out_push = advance && r_b1_valid && r_b1_last;
    assign out_pop  = pop && !empty;

    // Multiply stage: one signed 32 by 32 product per operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (advance) begin
            r_b1_valid <= !i_op_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b1_prod  <= SUM_W'(i_op.value) * SUM_W'(i_op.vec);
            r_b1_first <= i_op.first;
            r_b1_last  <= i_op.last;
            r_b1_row   <= i_op.row;
            r_b1_final <= i_op.final_row;
        end
    end

    // Saturating accumulation; the first column of a row starts from zero.
    always_comb begin
        acc_base = r_b1_first ? '0 : r_acc;
        acc_sum  = acc_base + r_b1_prod;
        acc_ovf  = (acc_base[SUM_W-1] == r_b1_prod[SUM_W-1]) &&
                   (acc_sum[SUM_W-1] != acc_base[SUM_W-1]);
        n_acc    = r_acc;
        if (advance && r_b1_valid) begin
            if (acc_ovf) begin
                n_acc = acc_base[SUM_W-1] ? SUM_MIN : SUM_MAX;
            end else begin
                n_acc = acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr_ptr <= '0;
            r_out_rd_ptr <= '0;
            r_out_count  <= '0;
        end else begin
            if (out_push) begin
                r_out_wr_ptr <= QUEUE_PTR_W'(r_out_wr_ptr + 1'b1);
            end
            if (out_pop) begin
                r_out_rd_ptr <= QUEUE_PTR_W'(r_out_rd_ptr + 1'b1);
            end
            unique case ({out_push, out_pop})
                2'b10:   r_out_count <= r_out_count + 1'b1;
                2'b01:   r_out_count <= r_out_count - 1'b1;
                default: r_out_count <= r_out_count;
            endcase
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out_sum[r_out_wr_ptr]   <= n_acc;
            r_out_row[r_out_wr_ptr]   <= r_b1_row;
            r_out_final[r_out_wr_ptr] <= r_b1_final;
        end
    end

    assign empty       = (r_out_count == '0);
    assign o_row_sum   = r_out_sum[r_out_rd_ptr];
    assign o_row_index = r_out_row[r_out_rd_ptr];
    assign o_final_row = r_out_final[r_out_rd_ptr];

    // Checks on the back end.
    `SMVM_ASSERT_SAME(a_out_count_bound, 1'b1, r_out_count <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH), "result queue overfilled")
    `SMVM_ASSERT_NEXT(a_stall_holds, !advance && r_b1_valid, r_b1_valid && $stable(r_b1_prod), "multiply stage lost its operation while stalled")
    `SMVM_ASSERT_NEXT(a_row_end_queued, out_push && !out_pop, !empty, "finished row sum not queued")
    `SMVM_ASSERT_NEXT(a_stall_acc_holds, !advance, $stable(r_acc), "accumulator changed while stalled")

endmodule

// ----- hw/rtl/square_matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// Square matrix-vector multiply, y = A * x, in signed fixed point
// Top level: front end, operation queue and multiply-accumulate back end.
// ----------------------------------------------------------------------------
// Usage. Set the matrix order through i_cfg_wr_en / i_cfg_wr_data while idle.
// Input transactions (push, full) carry a command and a Q16.16 value: a load
// stores the next vector element and returns the matrix position to row 0,
// column 0; a matrix element streams in row-major order. After the last column
// of a row, a Q32.32 saturated row sum with its row index and a last-row flag
// appears on the result side (empty, pop), oldest first.
// Throughput: one transaction per cycle while full is low, set by the single
// multiplier and the single vector store read port, each used once per matrix
// element. A row sum reaches the result queue through the stage register with
// store read, the operation queue and the multiply stage, then accumulation;
// it can then be popped from the result ports.
// Reset clears positions, the accumulator and both queues and sets the order
// to one; the vector store is undefined until loaded.
// When the receiver stalls, the four-entry result queue fills, the back end
// holds, the operation queue fills and full is raised; nothing is lost.
// ----------------------------------------------------------------------------
module square_matrix_vector_multiply (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [smvm_pkg::ORDER_W-1:0]        i_cfg_wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_command,
    input  logic signed [smvm_pkg::VALUE_W-1:0] i_value,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [smvm_pkg::SUM_W-1:0]   o_row_sum,
    output logic [smvm_pkg::ADDR_W-1:0]         o_row_index,
    output logic                                o_final_row
);

    import smvm_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    t_op  q_in, q_out;

    // Front end: positions, vector store and operation issue.
    smvm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_op_valid    (q_push),
        .o_op          (q_in),
        .i_op_full     (q_full)
    );

    // Operation queue between front and back.
    smvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (q_out),
        .o_empty (q_empty)
    );

    // Back end: multiply, accumulate and result queue.
    smvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (q_out),
        .i_op_empty  (q_empty),
        .o_op_pop    (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_row_sum   (o_row_sum),
        .o_row_index (o_row_index),
        .o_final_row (o_final_row)
    );

endmodule

// ----- dv/square_matrix_vector_multiply_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the square matrix-vector multiply block
// Loads vectors and streams row-major matrix elements through the push side,
// pops row sums from the result side and checks every field against a
// transaction-level predictor with saturating Q32.32 accumulation. The matrix
// order is changed between phases, while the block is idle.
// ----------------------------------------------------------------------------
module square_matrix_vector_multiply_tb;
    import smvm_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int SETTLE     = 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int SMALL_MAX  = 64;
    localparam int LARGE_RUN  = 24;

    // One row sum as the block reports it.
    typedef struct {
        logic signed [SUM_W-1:0] row_sum;
        logic [ADDR_W-1:0]       row_index;
        logic                    last_row;
    } t_row_sum;

    // Predicts row sums from accepted transactions and checks popped results.
    class row_sum_scoreboard;
        logic signed [VALUE_W-1:0] vec_mem [MAX_ORDER];
        bit                        vec_loaded [MAX_ORDER];
        int unsigned               load_pos;
        int unsigned               col_pos;
        int unsigned               row_pos;
        logic signed [SUM_W-1:0]   acc;
        logic [ORDER_W-1:0]        order;
        t_row_sum                  sums_due [$];
        int unsigned               mismatches;
        int unsigned               rows_checked;
        int unsigned               saturated_rows;

        function new();
            load_pos = 0;
            col_pos = 0;
            row_pos = 0;
            acc = '0;
            order = 1;
            mismatches = 0;
            rows_checked = 0;
            saturated_rows = 0;
            foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;
        endfunction

        // An order of zero behaves as one, and anything beyond the store as its size.
        function int unsigned eff_order();
            if (order == 0) return 1;
            if (order > MAX_ORDER) return MAX_ORDER;
            return order;
        endfunction

        function void set_order(logic [ORDER_W-1:0] value);
            order = value;
        endfunction

        // True when the column the next matrix element will use has been loaded.
        function bit column_loaded();
            return vec_loaded[(col_pos >= eff_order()) ? 0 : col_pos];
        endfunction

        function int pending();
            return sums_due.size();
        endfunction

        // Updates the predicted state for one accepted transaction.
        function void note_input(t_cmd cmd, logic signed [VALUE_W-1:0] value);
            int unsigned             n;
            logic signed [SUM_W-1:0] a_ext;
            logic signed [SUM_W-1:0] b_ext;
            logic signed [SUM_W-1:0] prod;
            logic signed [SUM_W-1:0] sum;
            t_row_sum                r;
            n = eff_order();
            if (cmd == CMD_LOAD) begin
                if (load_pos >= n) load_pos = 0;
                vec_mem[load_pos] = value;
                vec_loaded[load_pos] = 1'b1;
                load_pos = (load_pos + 1 >= n) ? 0 : load_pos + 1;
                col_pos = 0;
                row_pos = 0;
                acc = '0;
                return;
            end
            // Positions left beyond a shrunken order start again from zero.
            if (col_pos >= n) col_pos = 0;
            if (row_pos >= n) row_pos = 0;
            a_ext = value;
            b_ext = vec_mem[col_pos];
            prod = a_ext * b_ext;
            sum = acc + prod;
            if (acc[SUM_W-1] == prod[SUM_W-1] && sum[SUM_W-1] != acc[SUM_W-1]) begin
                sum = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
            end
            acc = sum;
            if (col_pos + 1 < n) begin
                col_pos++;
                return;
            end
            r.row_sum = acc;
            r.row_index = ADDR_W'(row_pos);
            r.last_row = (row_pos + 1 >= n);
            sums_due.push_back(r);
            acc = '0;
            col_pos = 0;
            row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
        endfunction

        // Compares one popped result with the oldest predicted row sum.
        function void check_result(logic signed [SUM_W-1:0] row_sum,
                                   logic [ADDR_W-1:0] row_index, logic last_row);
            t_row_sum want;
            if (sums_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected row result: sum %h row %0d last %0b",
                             row_sum, row_index, last_row);
                end
                return;
            end
            want = sums_due.pop_front();
            rows_checked++;
            if (want.row_sum == SUM_MAX || want.row_sum == SUM_MIN) saturated_rows++;
            if (row_sum !== want.row_sum || row_index !== want.row_index ||
                last_row !== want.last_row) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Row result mismatch: expected sum %h row %0d last %0b,",
                             want.row_sum, want.row_index, want.last_row,
                             " got sum %h row %0d last %0b",
                             row_sum, row_index, last_row);
                end
            end
        endfunction
    endclass

    // Block interface, all inputs known from time zero.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [ORDER_W-1:0]        i_cfg_wr_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic                      i_command = 1'b0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic signed [SUM_W-1:0]   o_row_sum;
    logic [ADDR_W-1:0]         o_row_index;
    logic                      o_final_row;

    row_sum_scoreboard sb = new();
    int unsigned       cycle_count = 0;
    int unsigned       items_sent = 0;
    int unsigned       loads_sent = 0;
    int unsigned       elements_sent = 0;
    int unsigned       orders_used = 0;

    square_matrix_vector_multiply uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_value       (i_value),
        .empty         (empty),
        .pop           (pop),
        .o_row_sum     (o_row_sum),
        .o_row_index   (o_row_index),
        .o_final_row   (o_final_row)
    );

    // Clock generation.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Extreme values half of the time, otherwise fully random ones.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Sends one transaction after a random gap and waits until it is taken.
    task automatic send_item(t_cmd cmd, logic signed [VALUE_W-1:0] value);
        int gap;
        gap = ((items_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (full);
        sb.note_input(cmd, value);
        items_sent++;
        if (cmd == CMD_LOAD) loads_sent++;
        else elements_sent++;
    endtask

    // Holds the sender until every predicted row sum has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the order register; the caller has drained the block first.
    task automatic write_order(logic [ORDER_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_order(value);
        orders_used++;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Result side: random stalls, with stretches of continuous popping.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = ((sb.rows_checked / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            sb.check_result(o_row_sum, o_row_index, o_final_row);
        end
    end

    // Stimulus: directed cases, then random phases over several orders.
    initial begin
        logic [ORDER_W-1:0] phase_orders [14];
        int unsigned        n;
        int unsigned        budget;
        int unsigned        waited;
        int unsigned        r;
        phase_orders = '{11'd3, 11'd1, 11'd2, 11'd5, 11'd8, 11'd16, 11'd4,
                         11'd1024, 11'd2047, 11'd0, 11'd7, 11'd13, 11'd2, 11'd1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Order zero acts as one; the second load wraps onto element zero.
        write_order(11'd0);
        send_item(CMD_LOAD, 32'h0001_0000);
        send_item(CMD_LOAD, 32'h8000_0000);
        send_item(CMD_MATRIX, 32'h8000_0000);
        send_item(CMD_MATRIX, 32'h7FFF_FFFF);

        // Order four: extra loads wrap, a row saturates high, the next saturates low mid-row.
        wait_drained();
        write_order(11'd4);
        send_item(CMD_LOAD, 32'h0123_4567);
        send_item(CMD_LOAD, 32'h89AB_CDEF);
        send_item(CMD_LOAD, 32'h0000_0001);
        send_item(CMD_LOAD, 32'h7FFF_FFFF);
        repeat (3) send_item(CMD_LOAD, 32'h8000_0000);
        repeat (3) send_item(CMD_MATRIX, 32'h8000_0000);
        send_item(CMD_MATRIX, 32'h7FFF_FFFF);
        repeat (4) send_item(CMD_MATRIX, 32'h7FFF_FFFF);
        repeat (2) send_item(CMD_MATRIX, 32'hFFFF_FFFF);

        // Shrink to two: row, column and load positions lie beyond the order.
        wait_drained();
        write_order(11'd2);
        send_item(CMD_MATRIX, 32'h0001_0000);
        send_item(CMD_MATRIX, 32'hFFFF_0000);
        send_item(CMD_LOAD, 32'h1234_5678);
        send_item(CMD_MATRIX, 32'h0000_0000);
        send_item(CMD_MATRIX, 32'hFFFF_FFFF);

        // Random phases: small orders get a full vector and mostly clean row
        // streams; the largest orders get a short run over loaded columns only.
        foreach (phase_orders[p]) begin
            wait_drained();
            write_order(phase_orders[p]);
            n = sb.eff_order();
            if (n <= SMALL_MAX) begin
                repeat (n) send_item(CMD_LOAD, pick_value());
            end
            budget = (n <= SMALL_MAX) ? 40 + 2 * n : LARGE_RUN;
            repeat (budget) begin
                r = $urandom_range(0, 99);
                if (n <= SMALL_MAX && r < 2) wait_drained();
                if ((n <= SMALL_MAX && r < 6) || !sb.column_loaded()) begin
                    send_item(CMD_LOAD, pick_value());
                end else begin
                    send_item(CMD_MATRIX, pick_value());
                end
            end
        end

        // Final drain, bounded so that missing results are reported.
        push <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d row sums never arrived", sb.pending());
        end

        $display("Sent %0d transactions (%0d vector loads, %0d matrix elements)",
                 items_sent, loads_sent, elements_sent,
                 " over %0d order settings.", orders_used);
        $display("Checked %0d row sums, %0d of them saturated, with %0d mismatches.",
                 sb.rows_checked, sb.saturated_rows, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/smvm_pkg.sv
hw/rtl/smvm_ram.sv
hw/rtl/smvm_front.sv
hw/rtl/smvm_queue.sv
hw/rtl/smvm_back.sv
hw/rtl/square_matrix_vector_multiply.sv
dv/square_matrix_vector_multiply_tb.sv
